### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/tnc_pkg.sv
// ---------------------------------------------------------------------------
// tnc_pkg
// types and constants shared by the tag nesting checker
// ---------------------------------------------------------------------------
package tnc_pkg;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_B     = 8'h62;
   localparam logic [7:0] CHAR_H     = 8'h68;
   localparam logic [7:0] CHAR_R     = 8'h72;

   typedef enum logic [3:0] {
      MODE_TEXT  = 4'b0001,
      MODE_LT    = 4'b0010,
      MODE_OPEN  = 4'b0100,
      MODE_CLOSE = 4'b1000
   } mode_type;

   // parser to stack, one accepted transaction
   typedef struct packed {
      logic push;
      logic close;
      logic last;
      logic err_long;
      logic mode_text;
   } cmd_type;

   // stack back to top level
   typedef struct packed {
      logic err;
      logic depth_zero;
   } stat_type;

endpackage

### hw/rtl/tnc_parser.sv
// ---------------------------------------------------------------------------
// tnc_parser
// tag mode tracking and name collection, one byte per cycle while accept is high
// ---------------------------------------------------------------------------
module tnc_parser import tnc_pkg::*; #(
   parameter int MAX_NAME = 16,
   parameter int LEN_W    = $clog2(MAX_NAME + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               char_byte,
   input  logic                     end_of_line,
   output cmd_type                  cmd,
   output logic [MAX_NAME-1:0][7:0] name,
   output logic [LEN_W-1:0]         name_len
);

   localparam int IDX_W = $clog2(MAX_NAME);

   mode_type                 mode_ff, mode_in;
   logic [MAX_NAME-1:0][7:0] name_ff, name_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic                     push_req;
   logic                     is_brhr;

   assign is_brhr = (len_ff == LEN_W'(2)) && (name_ff[1] == CHAR_R) &&
                    ((name_ff[0] == CHAR_B) || (name_ff[0] == CHAR_H));

   always_comb begin
      mode_in      = mode_ff;
      name_in      = name_ff;
      len_in       = len_ff;
      push_req     = 1'b0;
      cmd          = '0;
      if (accept) begin
         unique case (mode_ff)
            MODE_TEXT: begin
               if (char_byte == CHAR_LT) begin
                  name_in = '0;
                  len_in  = '0;
                  mode_in = MODE_LT;
               end
            end
            MODE_LT: begin
               if (char_byte == CHAR_SLASH) begin
                  name_in = '0;
                  len_in  = '0;
                  mode_in = MODE_CLOSE;
               end else if (char_byte == CHAR_GT) begin
                  push_req = 1'b1;
                  mode_in  = MODE_TEXT;
               end else begin
                  mode_in = MODE_OPEN;
               end
            end
            MODE_OPEN: begin
               if (char_byte == CHAR_GT) begin
                  push_req = 1'b1;
                  mode_in  = MODE_TEXT;
               end
            end
            MODE_CLOSE: begin
               if (char_byte == CHAR_GT) begin
                  cmd.close = 1'b1;
                  mode_in   = MODE_TEXT;
               end
            end
            default: begin
               mode_in = MODE_TEXT;
            end
         endcase
         // name byte append
         if (mode_ff != MODE_TEXT && char_byte != CHAR_GT &&
             !(mode_ff == MODE_LT && char_byte == CHAR_SLASH)) begin
            if (len_ff < LEN_W'(MAX_NAME)) begin
               name_in[len_ff[IDX_W-1:0]] = char_byte;
               len_in = len_ff + LEN_W'(1);
            end else begin
               cmd.err_long = 1'b1;
            end
         end
         cmd.push      = push_req && !is_brhr;
         cmd.last      = end_of_line;
         cmd.mode_text = (mode_in == MODE_TEXT);
         if (end_of_line) begin
            mode_in = MODE_TEXT;
            name_in = '0;
            len_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
         len_ff  <= '0;
         name_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         name_ff <= name_in;
      end
   end

   assign name     = name_ff;
   assign name_len = len_ff;

endmodule

### hw/rtl/tnc_stack.sv
// ---------------------------------------------------------------------------
// tnc_stack
// name stack: top entry in registers, lower entries in a synchronous memory
// ---------------------------------------------------------------------------
module tnc_stack import tnc_pkg::*; #(
   parameter int MAX_NAME    = 16,
   parameter int STACK_DEPTH = 32,
   parameter int LEN_W       = $clog2(MAX_NAME + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  logic [MAX_NAME-1:0][7:0] name,
   input  logic [LEN_W-1:0]         name_len,
   output stat_type                 stat
);

   `include "assert_macros.svh"

   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int EW = MAX_NAME * 8 + LEN_W;

   logic [EW-1:0]            mem [STACK_DEPTH];
   logic [EW-1:0]            rd_ff;
   logic [MAX_NAME-1:0][7:0] top_name_ff, top_name_in;
   logic [LEN_W-1:0]         top_len_ff, top_len_in;
   logic [DW-1:0]            depth_ff, depth_in, depth_step;
   logic [AW-1:0]            wr_ptr, rd_ptr;
   logic                     full, empty, match;
   logic                     push_ok, pop_ok, wr_en;

   assign full    = (depth_ff == DW'(STACK_DEPTH));
   assign empty   = (depth_ff == '0);
   assign match   = (top_len_ff == name_len) && (top_name_ff == name);
   assign push_ok = cmd.push && !full;
   assign pop_ok  = cmd.close && !empty && match;
   assign wr_en   = push_ok && !empty;
   assign wr_ptr  = AW'(depth_ff - DW'(1));
   assign rd_ptr  = AW'(depth_ff - DW'(2));

   always_comb begin
      depth_step  = depth_ff;
      top_name_in = top_name_ff;
      top_len_in  = top_len_ff;
      if (push_ok) begin
         depth_step  = depth_ff + DW'(1);
         top_name_in = name;
         top_len_in  = name_len;
      end else if (pop_ok) begin
         depth_step  = depth_ff - DW'(1);
         top_name_in = rd_ff[EW-1:LEN_W];
         top_len_in  = rd_ff[LEN_W-1:0];
      end
      depth_in = cmd.last ? '0 : depth_step;
   end

   assign stat.err        = (cmd.push && full) || (cmd.close && !(pop_ok));
   assign stat.depth_zero = (depth_step == '0);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr] <= {top_name_ff, top_len_ff};
      end
      rd_ff <= mem[rd_ptr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
      top_name_ff <= top_name_in;
      top_len_ff  <= top_len_in;
   end

   // prefetched entry is only valid if depth held over the prior cycle
   `ASSERT_IMPL(a_pop_prefetch, clock, reset, pop_ok, $stable(depth_ff))
   `ASSERT_IMPL(a_depth_range, clock, reset, 1'b1, depth_ff <= DW'(STACK_DEPTH))
   `ASSERT_IMPL(a_one_op, clock, reset, cmd.push || cmd.close, !(cmd.push && cmd.close))

endmodule

### hw/rtl/tag_nesting_checker_top.sv
// ---------------------------------------------------------------------------
// tag_nesting_checker_top
// checks that the tags of one markup line nest correctly
// ---------------------------------------------------------------------------
// usage:
//   req channel carries one byte per transaction, req_tlast on the final byte
//   of a line. text outside tags is ignored; open tags are pushed on a name
//   stack (br and hr excepted) and close tags must match the top entry.
//   rsp channel carries one verdict per line: 0 correct nesting, 1 wrong.
//   throughput is one byte per cycle while req_tready is high; the top entry
//   sits in registers and the entry below is prefetched from memory every cycle.
//   the verdict is registered and shows in the cycle after the last byte.
//   a stalled verdict holds rsp and stops req only while it is still waiting;
//   bytes keep flowing as long as rsp_tready is high or no verdict is pending.
//   reset returns the parser to text mode with an empty stack and no verdict;
//   the stack memory needs no clearing pass, only entries below the depth are
//   used. after each verdict the next line starts in text mode with an empty stack.
// ---------------------------------------------------------------------------
module tag_nesting_checker_top import tnc_pkg::*; #(
   parameter int MAX_NAME    = 16,
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // char_byte
   input  logic       req_tlast,   // end_of_line
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // verdict, zero fill
);

   `include "assert_macros.svh"

   localparam int LEN_W = $clog2(MAX_NAME + 1);

   cmd_type                  cmd;
   stat_type                 stat;
   logic [MAX_NAME-1:0][7:0] name;
   logic [LEN_W-1:0]         name_len;
   logic                     accept;
   logic                     wrong_ff, wrong_in, wrong_now;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     verdict_ff, verdict_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   tnc_parser #(
      .MAX_NAME (MAX_NAME),
      .LEN_W    (LEN_W)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_byte   (req_tdata),
      .end_of_line (req_tlast),
      .cmd         (cmd),
      .name        (name),
      .name_len    (name_len)
   );

   tnc_stack #(
      .MAX_NAME    (MAX_NAME),
      .STACK_DEPTH (STACK_DEPTH),
      .LEN_W       (LEN_W)
   ) u_stack (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .name     (name),
      .name_len (name_len),
      .stat     (stat)
   );

   always_comb begin
      wrong_now    = wrong_ff || cmd.err_long || stat.err;
      wrong_in     = cmd.last ? 1'b0 : wrong_now;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      verdict_in   = verdict_ff;
      if (accept && req_tlast) begin
         rsp_valid_in = 1'b1;
         verdict_in   = wrong_now || !cmd.mode_text || !stat.depth_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrong_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wrong_ff     <= wrong_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      verdict_ff <= verdict_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, verdict_ff};

   `ASSERT_IMPL(a_rsp_from_last, clock, reset, $rose(rsp_valid_ff), $past(accept && req_tlast))
   `ASSERT_NEXT(a_line_clears, clock, reset, accept && req_tlast, !wrong_ff)
   `ASSERT_IMPL(a_no_accept_stalled, clock, reset, rsp_valid_ff && !rsp_tready, !accept)

endmodule
